### sv/g2dc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package g2dc_pkg;

  localparam int PIX_W           = 8;
  localparam int COEFF_W         = 16;
  localparam int CRD_IN_W        = 8;
  localparam int KSZ_W           = 4;
  localparam int KSZ_MAX         = 15;
  localparam int DIMREG_W        = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 9;
  localparam int CRD_W           = 11;
  localparam int PROD_W          = PIX_W + 1 + COEFF_W;
  localparam int ACC_W           = PROD_W + $clog2(KSZ_MAX * KSZ_MAX);
  localparam int COEFF_FRAC_BITS = 12;

  localparam logic [KSZ_W-1:0]    KSZ_RST    = 4'd3;
  localparam logic [DIMREG_W-1:0] DIM_RST    = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD_PIX   = 2'd0,
    OP_LOAD_COEFF = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KSIZE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ABS,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic start;
    logic wr_img;
    logic wr_ker;
    logic issue;
    logic abs_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### sv/g2dc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface g2dc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [7:0]         row;
  logic [7:0]         col;
  logic [7:0]         pixel;
  logic signed [15:0] coeff;

  modport source (output valid, output op, output row, output col, output pixel,
                  output coeff, input ready);
  modport sink   (input valid, input op, input row, input col, input pixel,
                  input coeff, output ready);
endinterface

interface g2dc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered;
  logic       clipped;
  logic [7:0] out_row;
  logic [7:0] out_col;

  modport source (output valid, output filtered, output clipped, output out_row,
                  output out_col, input ready);
  modport sink   (input valid, input filtered, input clipped, input out_row,
                  input out_col, output ready);
endinterface
`default_nettype wire

### sv/grayscale_2d_convolution.sv
`timescale 1ns / 1ps
`default_nettype none
// channel    kind          carries
// in_chan    valid/ready   op, row, col, pixel, coeff
// out_chan   valid/ready   filtered, clipped, out_row, out_col
// cfg_*      write only    kernel_size (0), image_width (1), image_height (2)
//
// Loads are taken only in the idle state. A compute issues one multiply-accumulate
// per window tap; no new input is taken until its result is registered for output.
// Synchronous active-low reset; image and kernel memories are not cleared.
// A waiting result stalls only the next compute at its last step.
module grayscale_2d_convolution #(
  parameter int MAX_DIM    = 256,
  parameter int MAX_KERNEL = 15
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  g2dc_in_if.sink         in_chan,
  g2dc_out_if.source      out_chan,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [8:0] cfg_wdata
);

  g2dc_pkg::cmd_t cmd;
  g2dc_pkg::sts_t sts;

  g2dc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.op),
    .in_ready (in_chan.ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  g2dc_dp #(.MAX_DIM(MAX_DIM), .MAX_KERNEL(MAX_KERNEL)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_row       (in_chan.row),
    .in_col       (in_chan.col),
    .in_pixel     (in_chan.pixel),
    .in_coeff     (in_chan.coeff),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_filtered (out_chan.filtered),
    .out_clipped  (out_chan.clipped),
    .out_row      (out_chan.out_row),
    .out_col      (out_chan.out_col),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
`default_nettype wire

### sv/g2dc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module g2dc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/g2dc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module g2dc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_op,
  output logic               in_ready,
  input  wire g2dc_pkg::sts_t sts_i,
  output g2dc_pkg::cmd_t     cmd_o
);

  g2dc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= g2dc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      g2dc_pkg::ST_IDLE: begin
        if (in_valid && (in_op == g2dc_pkg::OP_COMPUTE)) state_nxt = g2dc_pkg::ST_RUN;
      end
      g2dc_pkg::ST_RUN: begin
        if (sts_i.last_tap) state_nxt = g2dc_pkg::ST_DRAIN;
      end
      g2dc_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_nxt = g2dc_pkg::ST_ABS;
      end
      g2dc_pkg::ST_ABS: begin
        state_nxt = g2dc_pkg::ST_ROUND;
      end
      g2dc_pkg::ST_ROUND: begin
        if (sts_i.out_free) state_nxt = g2dc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = g2dc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    unique case (state_r)
      g2dc_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.start   = in_valid && (in_op == g2dc_pkg::OP_COMPUTE);
        cmd_o.wr_img  = in_valid && (in_op == g2dc_pkg::OP_LOAD_PIX);
        cmd_o.wr_ker  = in_valid && (in_op == g2dc_pkg::OP_LOAD_COEFF);
      end
      g2dc_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
      end
      g2dc_pkg::ST_DRAIN: begin
      end
      g2dc_pkg::ST_ABS: begin
        cmd_o.abs_en = 1'b1;
      end
      g2dc_pkg::ST_ROUND: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/g2dc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module g2dc_dp #(
  parameter int MAX_DIM    = 256,
  parameter int MAX_KERNEL = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_idx,
  input  wire logic [8:0]            cfg_wdata,
  input  wire logic [7:0]            in_row,
  input  wire logic [7:0]            in_col,
  input  wire logic [7:0]            in_pixel,
  input  wire logic signed [15:0]    in_coeff,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [7:0]                 out_filtered,
  output logic                       out_clipped,
  output logic [7:0]                 out_row,
  output logic [7:0]                 out_col,
  input  wire g2dc_pkg::cmd_t        cmd_i,
  output g2dc_pkg::sts_t             sts_o
);

  localparam int KW   = g2dc_pkg::KSZ_W;
  localparam int DRW  = g2dc_pkg::DIMREG_W;
  localparam int CW   = g2dc_pkg::CRD_W;
  localparam int PW   = g2dc_pkg::PIX_W;
  localparam int FW   = g2dc_pkg::COEFF_W;
  localparam int PRW  = g2dc_pkg::PROD_W;
  localparam int AW   = g2dc_pkg::ACC_W;
  localparam int FRAC = g2dc_pkg::COEFF_FRAC_BITS;
  localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IMG_DEPTH = MAX_DIM * MAX_DIM;
  localparam int IA_W      = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KA_W      = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
  localparam int DIM_MAXV  = (1 << DRW) - 1;
  localparam logic [DRW-1:0] DIM_CAP = DRW'((MAX_DIM > DIM_MAXV) ? DIM_MAXV : MAX_DIM);
  localparam logic [KW-1:0]  KSZ_CAP =
    KW'((MAX_KERNEL > g2dc_pkg::KSZ_MAX) ? g2dc_pkg::KSZ_MAX : MAX_KERNEL);
  localparam logic [AW:0]    HALF    = (AW+1)'(1) << (FRAC - 1);

  // configuration
  logic [KW-1:0]  ksize_r;
  logic [DRW-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r  <= g2dc_pkg::KSZ_RST;
      width_r  <= g2dc_pkg::DIM_RST;
      height_r <= g2dc_pkg::DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        g2dc_pkg::CFG_KSIZE:  ksize_r  <= cfg_wdata[KW-1:0];
        g2dc_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[DRW-1:0];
        g2dc_pkg::CFG_HEIGHT: height_r <= cfg_wdata[DRW-1:0];
        default: ;
      endcase
    end
  end

  logic [KW-1:0]  c_eff;
  logic [KW:0]    c_p1;
  logic [KW-1:0]  half_c;
  logic [DRW-1:0] w_eff, h_eff;

  always_comb begin
    c_eff  = (ksize_r == '0) ? KW'(1) : ((ksize_r > KSZ_CAP) ? KSZ_CAP : ksize_r);
    c_p1   = {1'b0, c_eff} + (KW+1)'(1);
    half_c = c_p1[KW:1];
    w_eff  = (width_r == '0) ? DRW'(1) : ((width_r > DIM_CAP) ? DIM_CAP : width_r);
    h_eff  = (height_r == '0) ? DRW'(1) : ((height_r > DIM_CAP) ? DIM_CAP : height_r);
  end

  // per-item context and tap counters
  logic signed [CW-1:0] base_row_r, base_col_r;
  logic [7:0]           row_r, col_r;
  logic [KW-1:0]        cm1_r, i_r, j_r;
  logic [DRW-1:0]       wm1_r, hm1_r;

  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      base_row_r <= CW'(in_row) + CW'(1) - CW'(half_c);
      base_col_r <= CW'(in_col) + CW'(1) - CW'(half_c);
      row_r      <= in_row;
      col_r      <= in_col;
      cm1_r      <= c_eff - KW'(1);
      wm1_r      <= w_eff - DRW'(1);
      hm1_r      <= h_eff - DRW'(1);
    end
  end

  logic last_tap;
  assign last_tap = (i_r == cm1_r) && (j_r == cm1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd_i.start) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd_i.issue) begin
      if (j_r == cm1_r) begin
        j_r <= '0;
        i_r <= i_r + KW'(1);
      end else begin
        j_r <= j_r + KW'(1);
      end
    end
  end

  // window coordinates, clamped at both edges
  logic signed [CW-1:0] rr, qq;
  logic [CW-1:0]        r_cl, q_cl;

  always_comb begin
    rr = base_row_r + $signed(CW'(i_r));
    qq = base_col_r + $signed(CW'(j_r));
    if (rr < 0) begin
      r_cl = '0;
    end else if (rr > $signed(CW'(hm1_r))) begin
      r_cl = CW'(hm1_r);
    end else begin
      r_cl = rr;
    end
    if (qq < 0) begin
      q_cl = '0;
    end else if (qq > $signed(CW'(wm1_r))) begin
      q_cl = CW'(wm1_r);
    end else begin
      q_cl = qq;
    end
  end

  logic [DIM_W-1:0] r_a_r, q_a_r;
  logic [KW-1:0]    ki_a_r, kj_a_r;
  logic             v_a_r, v_b_r, v_c_r;

  always_ff @(posedge clk) begin
    r_a_r  <= DIM_W'(r_cl);
    q_a_r  <= DIM_W'(q_cl);
    ki_a_r <= i_r;
    kj_a_r <= j_r;
  end

  // memories
  logic            img_we, ker_we;
  logic [IA_W-1:0] img_waddr, img_raddr;
  logic [KA_W-1:0] ker_waddr, ker_raddr;
  logic [PW-1:0]   pix_rd;
  logic [FW-1:0]   coef_rd;

  assign img_we    = cmd_i.wr_img && (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign ker_we    = cmd_i.wr_ker && (32'(in_row) < MAX_KERNEL) && (32'(in_col) < MAX_KERNEL);
  assign img_waddr = IA_W'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign ker_waddr = KA_W'(32'(in_row) * MAX_KERNEL + 32'(in_col));
  assign img_raddr = IA_W'(32'(r_a_r) * MAX_DIM + 32'(q_a_r));
  assign ker_raddr = KA_W'(32'(ki_a_r) * MAX_KERNEL + 32'(kj_a_r));

  g2dc_ram #(.WIDTH(PW), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (in_pixel),
    .raddr (img_raddr),
    .rdata (pix_rd)
  );

  g2dc_ram #(.WIDTH(FW), .DEPTH(KER_DEPTH)) u_ker_ram (
    .clk   (clk),
    .we    (ker_we),
    .waddr (ker_waddr),
    .wdata (in_coeff),
    .raddr (ker_raddr),
    .rdata (coef_rd)
  );

  // multiply-accumulate
  logic signed [PRW-1:0] prod_r;
  logic signed [AW-1:0]  acc_r;

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, pix_rd}) * $signed(coef_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      v_a_r <= cmd_i.issue;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      acc_r <= '0;
    end else if (v_c_r) begin
      acc_r <= acc_r + AW'(prod_r);
    end
  end

  // rounding half away from zero, then saturation
  logic          neg_r;
  logic [AW-1:0] mag_r;
  logic [AW:0]   rsum, rnd;
  logic [7:0]    filt;
  logic          clip;

  always_ff @(posedge clk) begin
    if (cmd_i.abs_en) begin
      neg_r <= acc_r[AW-1];
      mag_r <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
    end
  end

  always_comb begin
    rsum = {1'b0, mag_r} + HALF;
    rnd  = rsum >> FRAC;
    if (rnd == '0) begin
      filt = '0;
      clip = 1'b0;
    end else if (neg_r) begin
      filt = '0;
      clip = 1'b1;
    end else if (|rnd[AW:8]) begin
      filt = 8'hff;
      clip = 1'b1;
    end else begin
      filt = rnd[7:0];
      clip = 1'b0;
    end
  end

  // result register
  logic       out_valid_r;
  logic [7:0] filt_r, orow_r, ocol_r;
  logic       clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      filt_r <= filt;
      clip_r <= clip;
      orow_r <= row_r;
      ocol_r <= col_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = filt_r;
  assign out_clipped  = clip_r;
  assign out_row      = orow_r;
  assign out_col      = ocol_r;

  assign sts_o.last_tap  = last_tap;
  assign sts_o.pipe_busy = v_a_r | v_b_r | v_c_r;
  assign sts_o.out_free  = !out_valid_r || out_ready;

  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.start |-> !(v_a_r || v_b_r || v_c_r))
    else $error("compute started with taps in flight");

  a_abs_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.abs_en |-> !(v_a_r || v_b_r || v_c_r))
    else $error("rounding began before the accumulator settled");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken transfer");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.issue && last_tap) |=> !cmd_i.issue)
    else $error("tap issued past the end of the window");

endmodule
`default_nettype wire

### tb/g2dc_checker.sv
`timescale 1ns / 1ps
module g2dc_checker
  import g2dc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  g2dc_in_if                    in_chan,
  g2dc_out_if                   out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int     DIM        = 256;
  localparam longint ROUND_HALF = longint'(1) << (COEFF_FRAC_BITS - 1);

  typedef struct packed {
    logic [PIX_W-1:0]    filtered;
    logic                clipped;
    logic [CRD_IN_W-1:0] out_row;
    logic [CRD_IN_W-1:0] out_col;
  } pixel_res_t;

  logic [PIX_W-1:0]    image_copy  [DIM*DIM];
  logic [COEFF_W-1:0]  kernel_copy [KSZ_MAX*KSZ_MAX];
  logic [KSZ_W-1:0]    ksize;
  logic [DIMREG_W-1:0] width_reg;
  logic [DIMREG_W-1:0] height_reg;
  pixel_res_t          expected_pixels [$];
  pixel_res_t          head;

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int dim_eff(logic [DIMREG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic pixel_res_t filter_pixel(logic [CRD_IN_W-1:0] r, logic [CRD_IN_W-1:0] c);
    int         k, w, h, half, wr, wc, i, j, p, q;
    longint     acc, rnd;
    pixel_res_t res;
    k    = (ksize == 0) ? 1 : int'(ksize);
    w    = dim_eff(width_reg);
    h    = dim_eff(height_reg);
    half = (k + 1) / 2;
    acc  = 0;
    for (i = 0; i < k; i++) begin
      wr = clamp_coord(int'(r) + 1 - half + i, h - 1);
      for (j = 0; j < k; j++) begin
        wc = clamp_coord(int'(c) + 1 - half + j, w - 1);
        p  = image_copy[wr*DIM + wc];
        q  = $signed(kernel_copy[i*KSZ_MAX + j]);
        acc += longint'(p * q);
      end
    end
    // round half away from zero
    if (acc >= 0) rnd = (acc + ROUND_HALF) >>> COEFF_FRAC_BITS;
    else rnd = -((-acc + ROUND_HALF) >>> COEFF_FRAC_BITS);
    if (rnd < 0) begin
      res.filtered = '0;
      res.clipped  = 1'b1;
    end else if (rnd > 255) begin
      res.filtered = '1;
      res.clipped  = 1'b1;
    end else begin
      res.filtered = rnd[PIX_W-1:0];
      res.clipped  = 1'b0;
    end
    res.out_row = r;
    res.out_col = c;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ksize      = KSZ_RST;
      width_reg  = DIM_RST;
      height_reg = DIM_RST;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KSIZE:  ksize      = cfg_wdata[KSZ_W-1:0];
          CFG_WIDTH:  width_reg  = cfg_wdata;
          CFG_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        case (in_chan.op)
          OP_LOAD_PIX: image_copy[{in_chan.row, in_chan.col}] = in_chan.pixel;
          OP_LOAD_COEFF: begin
            if (in_chan.row < KSZ_MAX && in_chan.col < KSZ_MAX)
              kernel_copy[in_chan.row*KSZ_MAX + in_chan.col] = in_chan.coeff;
          end
          OP_COMPUTE: expected_pixels.push_back(filter_pixel(in_chan.row, in_chan.col));
          default: ;
        endcase
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result transfer with no compute pending: row %0d col %0d",
                 out_chan.out_row, out_chan.out_col);
          mismatches++;
        end else begin
          head = expected_pixels.pop_front();
          if (out_chan.filtered !== head.filtered) begin
            $error("filtered: expected %0d, got %0d", head.filtered, out_chan.filtered);
            mismatches++;
          end
          if (out_chan.clipped !== head.clipped) begin
            $error("clipped: expected %0d, got %0d", head.clipped, out_chan.clipped);
            mismatches++;
          end
          if (out_chan.out_row !== head.out_row) begin
            $error("out_row: expected %0d, got %0d", head.out_row, out_chan.out_row);
            mismatches++;
          end
          if (out_chan.out_col !== head.out_col) begin
            $error("out_col: expected %0d, got %0d", head.out_col, out_chan.out_col);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import g2dc_pkg::*;

  localparam int         DIM          = 256;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 170;
  localparam int         IDLE_LIMIT   = 5000;
  localparam int         DRAIN_CYCLES = KSZ_MAX*KSZ_MAX + 16;
  localparam int         HOLD_AT      = 500;
  localparam int         HOLD_OFF     = 400;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  typedef enum int {CS_SMOOTH, CS_SIGNED, CS_RAW} coeff_style_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatches;
  int                    outstanding;

  int           sent;
  int           idle_pct;
  int           quiet_cycles;
  bit           held;
  int           k_eff, w_eff, h_eff;
  coeff_style_t coeff_style;
  int           cr_lo, cr_hi, cc_lo, cc_hi, lr_lo, lr_hi, lc_lo, lc_hi;
  bit           img_done [DIM*DIM];
  bit           ker_done [KSZ_MAX*KSZ_MAX];

  int           ph_k     [PHASES] = '{3, 1, 15, 5, 0, 2, 7, 15, 496, 4};
  int           ph_w     [PHASES] = '{256, 1, 3, 16, 300, 256, 9, 256, 0, 12};
  int           ph_h     [PHASES] = '{256, 256, 2, 1, 7, 1, 9, 256, 511, 10};
  int           ph_idle  [PHASES] = '{15, 25, 10, 0, 30, 15, 20, 10, 25, 0};
  coeff_style_t ph_style [PHASES] = '{CS_SMOOTH, CS_SIGNED, CS_SMOOTH, CS_RAW, CS_SMOOTH,
                                      CS_SIGNED, CS_SMOOTH, CS_SMOOTH, CS_SIGNED, CS_SMOOTH};

  g2dc_in_if  in_chan ();
  g2dc_out_if out_chan ();

  grayscale_2d_convolution uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  g2dc_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    int span;
    span = 8192 / (k_eff * k_eff);
    if (coeff_style == CS_RAW || $urandom_range(0, 9) == 0) return 16'($urandom);
    if (coeff_style == CS_SIGNED) return 16'(int'($urandom_range(0, 2 * span)) - span);
    return 16'($urandom_range(0, span));
  endfunction

  task automatic send_item(logic [1:0] op, logic [7:0] r, logic [7:0] c, logic [7:0] px,
                           logic [15:0] cf);
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.op    <= op;
    in_chan.row   <= r;
    in_chan.col   <= c;
    in_chan.pixel <= px;
    in_chan.coeff <= cf;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
    if (op == OP_LOAD_PIX) img_done[{r, c}] = 1'b1;
    else if (op == OP_LOAD_COEFF && r < KSZ_MAX && c < KSZ_MAX) ker_done[r*KSZ_MAX + c] = 1'b1;
  endtask

  // fill any window tap not yet written, then request the pixel
  task automatic compute_at(logic [7:0] r, logic [7:0] c);
    int half, i, j, wr, wc;
    half = (k_eff + 1) / 2;
    for (i = 0; i < k_eff; i++) begin
      for (j = 0; j < k_eff; j++) begin
        if (!ker_done[i*KSZ_MAX + j])
          send_item(OP_LOAD_COEFF, 8'(i), 8'(j), 8'($urandom), pick_coeff());
        wr = clamp_coord(int'(r) + 1 - half + i, h_eff - 1);
        wc = clamp_coord(int'(c) + 1 - half + j, w_eff - 1);
        if (!img_done[wr*DIM + wc])
          send_item(OP_LOAD_PIX, 8'(wr), 8'(wc), 8'($urandom), 16'($urandom));
      end
    end
    send_item(OP_COMPUTE, r, c, 8'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(int ks, int w, int h);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_KSIZE;
    cfg_wdata <= 9'(ks);
    @(negedge clk);
    cfg_idx   <= CFG_WIDTH;
    cfg_wdata <= 9'(w);
    @(negedge clk);
    cfg_idx   <= CFG_HEIGHT;
    cfg_wdata <= 9'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    k_eff = (ks % 16 == 0) ? 1 : ks % 16;
    w_eff = (w % 512 == 0) ? 1 : ((w % 512 > DIM) ? DIM : w % 512);
    h_eff = (h % 512 == 0) ? 1 : ((h % 512 > DIM) ? DIM : h % 512);
  endtask

  // small images: centres anywhere; large ones: a 4-wide band near an edge or inside
  task automatic set_span(input int dim, input int anchor, output int c_lo, output int c_hi,
                          output int l_lo, output int l_hi);
    int b;
    if (dim <= 16) begin
      c_lo = 0;
      c_hi = DIM - 1;
      l_lo = 0;
      l_hi = dim - 1;
    end else begin
      case (anchor)
        0:       b = 0;
        1:       b = dim - 4;
        default: b = $urandom_range(0, dim - 4);
      endcase
      c_lo = b;
      c_hi = b + 3;
      l_lo = (b > 7) ? b - 7 : 0;
      l_hi = (b + 10 < dim) ? b + 10 : dim - 1;
    end
  endtask

  task automatic random_item();
    int pick, sel, ki, kj;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      compute_at(8'($urandom_range(cr_lo, cr_hi)), 8'($urandom_range(cc_lo, cc_hi)));
    end else if (pick < 75) begin
      if ($urandom_range(0, 2) == 0)
        send_item(OP_LOAD_PIX, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      else
        send_item(OP_LOAD_PIX, 8'($urandom_range(lr_lo, lr_hi)), 8'($urandom_range(lc_lo, lc_hi)),
                  8'($urandom), 16'($urandom));
    end else if (pick < 93) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        ki = $urandom_range(0, k_eff - 1);
        kj = $urandom_range(0, k_eff - 1);
      end else if (sel < 9) begin
        ki = $urandom_range(0, KSZ_MAX);
        kj = $urandom_range(0, KSZ_MAX);
      end else begin
        ki = $urandom_range(0, 255);
        kj = $urandom_range(0, 255);
      end
      send_item(OP_LOAD_COEFF, 8'(ki), 8'(kj), 8'($urandom), pick_coeff());
    end else begin
      send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        out_chan.ready <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    int p, start;
    in_chan.valid = 1'b0;
    in_chan.op    = OP_LOAD_PIX;
    in_chan.row   = '0;
    in_chan.col   = '0;
    in_chan.pixel = '0;
    in_chan.coeff = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: single-tap kernel for exact rounding and saturation cases
    idle_pct    = 10;
    coeff_style = CS_SMOOTH;
    set_regs(1, DIM, DIM);
    send_item(OP_LOAD_COEFF, 8'd0, 8'd0, 8'd0, 16'h0800);
    send_item(OP_LOAD_PIX, 8'd0, 8'd0, 8'd1, 16'h0000);
    compute_at(8'd0, 8'd0);
    send_item(OP_LOAD_PIX, 8'd255, 8'd255, 8'd3, 16'hFFFF);
    compute_at(8'd255, 8'd255);
    send_item(OP_LOAD_COEFF, 8'd0, 8'd0, 8'hFF, 16'hF800);
    compute_at(8'd0, 8'd0);
    compute_at(8'd255, 8'd255);
    send_item(OP_LOAD_COEFF, 8'd15, 8'd0, 8'd0, 16'h1000);
    send_item(OP_LOAD_COEFF, 8'd0, 8'd15, 8'd0, 16'h1000);
    send_item(OP_LOAD_COEFF, 8'd255, 8'd255, 8'd0, 16'h7FFF);
    compute_at(8'd0, 8'd0);
    send_item(OP_LOAD_COEFF, 8'd0, 8'd0, 8'd0, 16'h7FFF);
    send_item(OP_LOAD_PIX, 8'd0, 8'd255, 8'd255, 16'h0000);
    compute_at(8'd0, 8'd255);
    send_item(OP_LOAD_COEFF, 8'd0, 8'd0, 8'd0, 16'h8000);
    compute_at(8'd0, 8'd255);
    send_item(OP_LOAD_COEFF, 8'd0, 8'd0, 8'd0, 16'h1000);
    send_item(OP_LOAD_PIX, 8'd255, 8'd0, 8'd0, 16'h0000);
    compute_at(8'd255, 8'd0);
    compute_at(8'd0, 8'd255);
    send_item(OP_UNUSED, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    compute_at(8'd255, 8'd255);

    for (p = 0; p < PHASES; p++) begin
      idle_pct    = ph_idle[p];
      coeff_style = ph_style[p];
      set_regs(ph_k[p], ph_w[p], ph_h[p]);
      set_span(h_eff, p % 3, cr_lo, cr_hi, lr_lo, lr_hi);
      set_span(w_eff, (p + 1) % 3, cc_lo, cc_hi, lc_lo, lc_hi);
      start = sent;
      while (sent - start < PHASE_ITEMS) random_item();
    end

    settle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
